>>> sv/motsa_pkg.sv
package motsa_pkg;

  localparam int DATA_W = 32;

  typedef struct packed {
    logic signed [DATA_W-1:0] a_value;
    logic signed [DATA_W-1:0] b_value;
    logic                     last_pair;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] median;
    logic                     overflow;
  } out_item_t;

endpackage

>>> sv/median_of_two_sorted_arrays.sv
// pairs load at one item per cycle while no search is running
// after the last pair the search runs a read/compare loop (S_RD, then S_CMP) through the
// memories' read port until it reaches the result
// input stalls from the last pair until the result is in the output register
// reset (rst_n low, synchronous) empties the stored sequence and the output;
// element memories are not cleared and are only read where written
module median_of_two_sorted_arrays
  import motsa_pkg::*;
#(
  parameter int MAX_LEN = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam logic [CW-1:0] FULL = CW'(MAX_LEN);

  typedef enum logic [2:0] {
    S_LOAD,
    S_RD,
    S_CMP,
    S_FIN,
    S_OUT
  } state_t;

  state_t state_r;

  logic [DATA_W-1:0] mem_a [MAX_LEN];
  logic [DATA_W-1:0] mem_b [MAX_LEN];
  logic [DATA_W-1:0] rd_a_r;
  logic [DATA_W-1:0] rd_b_r;

  logic [CW-1:0] count_r;
  logic          ovf_r;
  logic          ovf_res_r;
  logic [CW-1:0] lo1_r;
  logic [CW-1:0] hi1_r;
  logic [CW-1:0] lo2_r;
  logic [CW-1:0] hi2_r;
  logic [CW-1:0] m1_r;
  logic [CW-1:0] m2_r;
  logic signed [DATA_W-1:0] res_r;
  logic      out_valid_r;
  out_item_t out_item_r;

  logic          in_acc;
  logic          full;
  logic          wr_en;
  logic          searching;
  logic [CW:0]   sum1;
  logic [CW:0]   sum2;
  logic [CW-1:0] mid1;
  logic [CW-1:0] mid2;
  logic [AW-1:0] rd_addr_a;
  logic [AW-1:0] rd_addr_b;
  logic signed [DATA_W-1:0] va;
  logic signed [DATA_W-1:0] vb;

  assign in_stall  = (state_r != S_LOAD);
  assign in_acc    = in_valid && !in_stall;
  assign full      = (count_r == FULL);
  assign wr_en     = in_acc && !full;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // midpoints of [lo, hi)
  assign sum1 = {1'b0, lo1_r} + {1'b0, hi1_r} - (CW+1)'(1);
  assign sum2 = {1'b0, lo2_r} + {1'b0, hi2_r} - (CW+1)'(1);
  assign mid1 = sum1[CW:1];
  assign mid2 = sum2[CW:1];

  assign searching = (({1'b0, lo1_r} + (CW+1)'(1)) < {1'b0, hi1_r}) ||
                     (({1'b0, lo2_r} + (CW+1)'(1)) < {1'b0, hi2_r});

  assign rd_addr_a = searching ? mid1[AW-1:0] : lo1_r[AW-1:0];
  assign rd_addr_b = searching ? mid2[AW-1:0] : lo2_r[AW-1:0];

  assign va = signed'(rd_a_r);
  assign vb = signed'(rd_b_r);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_a[count_r[AW-1:0]] <= in_item.a_value;
      mem_b[count_r[AW-1:0]] <= in_item.b_value;
    end
    rd_a_r <= mem_a[rd_addr_a];
    rd_b_r <= mem_b[rd_addr_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!out_stall && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_LOAD: begin
          if (in_acc) begin
            if (in_item.last_pair) begin
              lo1_r     <= '0;
              lo2_r     <= '0;
              hi1_r     <= full ? FULL : count_r + CW'(1);
              hi2_r     <= full ? FULL : count_r + CW'(1);
              ovf_res_r <= ovf_r | full;
              count_r   <= '0;
              ovf_r     <= 1'b0;
              state_r   <= S_RD;
            end else if (!full) begin
              count_r <= count_r + CW'(1);
            end else begin
              ovf_r <= 1'b1;
            end
          end
        end
        S_RD: begin
          // read address is presented this cycle, data is back next cycle
          m1_r    <= mid1;
          m2_r    <= mid2;
          state_r <= searching ? S_CMP : S_FIN;
        end
        S_CMP: begin
          if (va == vb) begin
            res_r   <= va;
            state_r <= S_OUT;
          end else begin
            if (vb < va) begin
              lo2_r <= (hi1_r[0] ^ lo1_r[0]) ? m2_r : m2_r + CW'(1);
              hi1_r <= m1_r + CW'(1);
            end else begin
              lo1_r <= (hi2_r[0] ^ lo2_r[0]) ? m1_r : m1_r + CW'(1);
              hi2_r <= m2_r + CW'(1);
            end
            state_r <= S_RD;
          end
        end
        S_FIN: begin
          res_r   <= (va < vb) ? va : vb;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r         <= 1'b1;
            out_item_r.median   <= res_r;
            out_item_r.overflow <= ovf_res_r;
            state_r             <= S_LOAD;
          end
        end
        default: begin
          state_r <= S_LOAD;
        end
      endcase
    end
  end

endmodule

>>> sv/motsa_checker.sv
module motsa_props
  import motsa_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  // last pair starts a search, so the input is busy right after it
  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_item.last_pair |=> in_stall)
    else $error("input not stalled after last pair");

  // an ordinary pair never brings a result with it
  a_no_result_mid_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_item.last_pair |=> !$rose(out_valid))
    else $error("result after a non-final pair");

  // a new result only comes out of a search
  a_result_after_search: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a search");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

endmodule

bind median_of_two_sorted_arrays motsa_props u_motsa_props (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
